### rtl/arpm_pkg.sv
// ----------------------------------------------------------------------------
// arpm_pkg: shared constants for the RMS / peak level meter
// Widths of the accumulator and of the fixed-point log2 unit.
// ----------------------------------------------------------------------------
package arpm_pkg;

  localparam int SUM_W          = 50;  // square sum width
  localparam int LOG_W          = 50;  // log2 unit operand width (>= 32)
  localparam int FRAC_W         = 24;  // log2 fraction bits (Q24)
  localparam int LOG_RES_W      = 32;  // log2 result width
  localparam int BAR_CELLS_DEF  = 20;
  localparam int COUNT_BITS_DEF = 20;

  localparam logic [7:0]  FPR_RESET    = 8'd5;
  localparam logic [28:0] LOG_K        = 29'd505044526; // 100*log10(2), Q24
  localparam logic [9:0]  FLOOR_TENTHS = 10'd960;

endpackage

### rtl/arpm_log2.sv
// ----------------------------------------------------------------------------
// arpm_log2: serial fixed-point log2
// Normalizes one bit per cycle, then forms one Q24 fraction bit per cycle
// by repeated squaring of the Q31 mantissa.
// ----------------------------------------------------------------------------
module arpm_log2 import arpm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [LOG_W-1:0]     x_i,
  output logic                 done_o,
  output logic [LOG_RES_W-1:0] res_o
);

  localparam int E_W  = $clog2(LOG_W);
  localparam int IT_W = $clog2(FRAC_W);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_ITER = 3'b100
  } lstate_e;

  lstate_e          state_q, state_d;
  logic             done_q, done_d;
  logic [LOG_W-1:0] x_q;
  logic [E_W-1:0]   e_q;
  logic [31:0]      m_q;
  logic [FRAC_W-1:0] frac_q;
  logic [IT_W-1:0]  it_q;
  logic [63:0]      sq;
  logic             norm_done;

  assign sq        = {32'b0, m_q} * {32'b0, m_q};
  assign norm_done = x_q[LOG_W-1] || (e_q == '0);

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      L_IDLE: if (start_i) state_d = L_NORM;
      L_NORM: if (norm_done) state_d = L_ITER;
      L_ITER: begin
        if (it_q == '0) begin
          state_d = L_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        x_q <= x_i;
        e_q <= E_W'(LOG_W - 1);
      end
      L_NORM: begin
        if (norm_done) begin
          m_q  <= x_q[LOG_W-1 -: 32];
          it_q <= IT_W'(FRAC_W - 1);
        end else begin
          x_q <= {x_q[LOG_W-2:0], 1'b0};
          e_q <= e_q - 1'b1;
        end
      end
      L_ITER: begin
        frac_q <= {frac_q[FRAC_W-2:0], sq[63]};
        m_q    <= sq[63] ? sq[63:32] : sq[62:31];
        it_q   <= it_q - 1'b1;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = LOG_RES_W'({e_q, frac_q});

endmodule

### rtl/audio_rms_peak_level_meter_core.sv
// ----------------------------------------------------------------------------
// audio_rms_peak_level_meter_core: RMS / peak level meter, dBFS report
// Accumulates square sum, peak, clip and sample counts over a number of
// frames and reports RMS and peak levels in tenths of dBFS plus a bar fill.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | input     | in_valid_i/in_ready_o| sample_i, sample_valid_i, frame_end_i
//  out     | output    | out_valid_o/ready_i  | rms/peak levels, clip_count, bar_fill
//  cfg     | input     | cfg_valid_i/ready_o  | cfg_data_i (frames_per_report)
//
// A sample item is captured, then squared and accumulated.
// A reporting frame end adds the report: three serial log2 runs, two
// multiply/round pairs and a bar count.
// The output register frees the input side: the next item is taken while a
// report waits; a second report waits only until the first is transferred.
// Reset clears all accumulators and sets frames_per_report to 5. cfg is
// always ready.
// ----------------------------------------------------------------------------
module audio_rms_peak_level_meter_core import arpm_pkg::*; #(
  parameter int BAR_CELLS  = BAR_CELLS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sample_i,
  input  logic               sample_valid_i,
  input  logic               frame_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [10:0] rms_level_tenths_db_o,
  output logic signed [10:0] peak_level_tenths_db_o,
  output logic [19:0]        clip_count_o,
  output logic [4:0]         bar_fill_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i
);

  localparam int FILL_W = $clog2(BAR_CELLS + 1);
  localparam int ACC_W  = $clog2(600 * BAR_CELLS + 301);
  localparam int CX_W   = COUNT_BITS + 20;
  localparam logic [LOG_RES_W-1:0] LD_PEAK = LOG_RES_W'(30) << FRAC_W;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_ACC  = 12'b000000000010,
    S_LSUM = 12'b000000000100,
    S_LCNT = 12'b000000001000,
    S_LPK  = 12'b000000010000,
    S_MULR = 12'b000000100000,
    S_RNDR = 12'b000001000000,
    S_MULP = 12'b000010000000,
    S_RNDP = 12'b000100000000,
    S_BARM = 12'b001000000000,
    S_BAR  = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // accumulators
  logic [SUM_W-1:0]      sum_q;
  logic [16:0]           peak_q;
  logic [COUNT_BITS-1:0] clip_q, cnt_q;
  logic [7:0]            ft_q;
  logic [7:0]            fpr_q;
  // captured item
  logic [16:0]           a_q;
  logic                  vld_q, fe_q;
  // report path
  logic                  go_q;
  logic [33:0]           psq_q;
  logic [LOG_RES_W-1:0]  ln_sum_q, ld_cnt_q, ln_pk_q;
  logic [60:0]           prod_q;
  logic                  spec_q;
  logic [9:0]            spec_val_q;
  logic [9:0]            rms_mag_q, pk_mag_q;
  logic [ACC_W-1:0]      acc_q;
  logic [FILL_W-1:0]     fill_q;
  // output register
  logic                  out_valid_q;
  logic [10:0]           rms_out_q, pk_out_q;
  logic [19:0]           clip_out_q;
  logic [4:0]            bar_out_q;

  // log2 unit
  logic                 log_start, log_done;
  logic [LOG_W-1:0]     log_x;
  logic [LOG_RES_W-1:0] log_res;

  arpm_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .res_o   (log_res)
  );

  always_comb begin
    case (state_q)
      S_LSUM:  log_x = LOG_W'(sum_q);
      S_LCNT:  log_x = LOG_W'(cnt_q);
      default: log_x = LOG_W'(psq_q);
    endcase
  end

  logic in_log;
  assign in_log    = (state_q == S_LSUM) || (state_q == S_LCNT) || (state_q == S_LPK);
  assign log_start = in_log && !go_q;

  // sample accumulate
  logic [33:0]    sq;
  logic [SUM_W:0] sum_ext;
  logic [7:0]     ft_new, limit;
  assign sq      = {17'b0, a_q} * {17'b0, a_q};
  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(sq);
  assign ft_new  = (ft_q == 8'hFF) ? ft_q : ft_q + 8'd1;
  assign limit   = (fpr_q == '0) ? 8'd1 : fpr_q;

  // level: shared between RMS and peak
  logic [LOG_RES_W-1:0] lv_ln, lv_ld;
  logic                 lv_zero;
  logic [LOG_RES_W:0]   lv_diff;
  logic [61:0]          rnd;
  logic [13:0]          r;
  logic [9:0]           lvl;
  always_comb begin
    if (state_q == S_MULR) begin
      lv_ln   = ln_sum_q;
      lv_ld   = ld_cnt_q;
      lv_zero = (sum_q == '0) || (cnt_q == '0);
    end else begin
      lv_ln   = ln_pk_q;
      lv_ld   = LD_PEAK;
      lv_zero = (peak_q == '0);
    end
  end
  assign lv_diff = {1'b0, lv_ld} - {1'b0, lv_ln};
  assign rnd     = {1'b0, prod_q} + (62'(1) << 47);
  assign r       = rnd[61:48];
  assign lvl     = spec_q ? spec_val_q : ((r > 14'(FLOOR_TENTHS)) ? FLOOR_TENTHS : r[9:0]);

  // bar and clip outputs
  logic [9:0]        bar_v;
  logic [CX_W-1:0]   clip_x;
  logic [FILL_W+4:0] fill_x;
  assign bar_v  = (rms_mag_q >= 10'd600) ? 10'd0 : 10'd600 - rms_mag_q;
  assign clip_x = CX_W'(clip_q);
  assign fill_x = (FILL_W + 5)'(fill_q);

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_ACC;
      S_ACC: begin
        if (fe_q && (ft_new >= limit)) state_d = S_LSUM;
        else                           state_d = S_IDLE;
      end
      S_LSUM:  if (go_q && log_done) state_d = S_LCNT;
      S_LCNT:  if (go_q && log_done) state_d = S_LPK;
      S_LPK:   if (go_q && log_done) state_d = S_MULR;
      S_MULR:  state_d = S_RNDR;
      S_RNDR:  state_d = S_MULP;
      S_MULP:  state_d = S_RNDP;
      S_RNDP:  state_d = S_BARM;
      S_BARM:  state_d = S_BAR;
      S_BAR: begin
        if (!((acc_q >= ACC_W'(600)) && (fill_q < FILL_W'(BAR_CELLS)))) state_d = S_OUT;
      end
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fpr_q       <= FPR_RESET;
      sum_q       <= '0;
      peak_q      <= '0;
      clip_q      <= '0;
      cnt_q       <= '0;
      ft_q        <= '0;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) fpr_q <= cfg_data_i;
      if (in_log) go_q <= !(go_q && log_done);
      // a new report replaces the one transferred at the same edge
      if ((state_q == S_OUT) && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_ACC: begin
          if (vld_q) begin
            sum_q <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            if (a_q > peak_q) peak_q <= a_q;
            if ((a_q >= 17'd32767) && (clip_q != '1)) clip_q <= clip_q + 1'b1;
            if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
          end
          if (fe_q) ft_q <= ft_new;
        end
        S_OUT: begin
          if (out_free) begin
            sum_q       <= '0;
            peak_q      <= '0;
            clip_q      <= '0;
            cnt_q       <= '0;
            ft_q        <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        a_q   <= sample_i[15] ? 17'h10000 - {1'b0, sample_i} : {1'b0, sample_i};
        vld_q <= sample_valid_i;
        fe_q  <= frame_end_i;
      end
      S_LSUM: begin
        psq_q <= {17'b0, peak_q} * {17'b0, peak_q};
        if (go_q && log_done) ln_sum_q <= log_res;
      end
      S_LCNT: if (go_q && log_done) ld_cnt_q <= log_res + LD_PEAK;
      S_LPK:  if (go_q && log_done) ln_pk_q <= log_res;
      S_MULR, S_MULP: begin
        spec_q     <= lv_zero || (lv_ln >= lv_ld) || (lv_diff > (LOG_RES_W + 1)'(33'h080000000));
        spec_val_q <= (lv_zero || (lv_ln < lv_ld)) ? FLOOR_TENTHS : 10'd0;
        prod_q     <= {29'b0, lv_diff[31:0]} * {32'b0, LOG_K};
      end
      S_RNDR: rms_mag_q <= lvl;
      S_RNDP: pk_mag_q  <= lvl;
      S_BARM: begin
        acc_q  <= ACC_W'(ACC_W'(bar_v) * ACC_W'(BAR_CELLS) + ACC_W'(300));
        fill_q <= '0;
      end
      S_BAR: begin
        if ((acc_q >= ACC_W'(600)) && (fill_q < FILL_W'(BAR_CELLS))) begin
          acc_q  <= acc_q - ACC_W'(600);
          fill_q <= fill_q + 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          rms_out_q  <= 11'd0 - {1'b0, rms_mag_q};
          pk_out_q   <= 11'd0 - {1'b0, pk_mag_q};
          clip_out_q <= (|clip_x[CX_W-1:20]) ? 20'hFFFFF : clip_x[19:0];
          bar_out_q  <= fill_x[4:0];
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o             = (state_q == S_IDLE);
  assign cfg_ready_o            = 1'b1;
  assign out_valid_o            = out_valid_q;
  assign rms_level_tenths_db_o  = rms_out_q;
  assign peak_level_tenths_db_o = pk_out_q;
  assign clip_count_o           = clip_out_q;
  assign bar_fill_o             = bar_out_q;

endmodule

### sim/audio_rms_peak_level_meter_core_test.sv
// ----------------------------------------------------------------------------
// audio_rms_peak_level_meter_core_test: self-checking bench for the level meter
// A directed table drives edge cases first, then random frames are sent under
// several frames_per_report settings. Every item is run through a local
// model of the meter. Reports must match the oldest expected report.
// ----------------------------------------------------------------------------
module audio_rms_peak_level_meter_core_test;
  import arpm_pkg::*;

  localparam int          CYCLE_LIMIT = 2000000;
  localparam int          DRAIN_WAIT  = 300;   // covers the longest report run
  localparam logic [63:0] SUM_CAP     = (64'd1 << SUM_W) - 64'd1;
  localparam logic [63:0] CNT_CAP     = (64'd1 << COUNT_BITS_DEF) - 64'd1;
  localparam int          RANDOM_ITEMS = 1000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic signed [10:0] rms;
    logic signed [10:0] peak;
    logic [19:0]        clip;
    logic [4:0]         bar;
  } level_report_t;

  // one stimulus row: an item or a register write; typed rows carry the report
  typedef struct packed {
    row_kind_e     kind;
    logic [7:0]    cfg;
    logic [15:0]   smp;
    logic          sv;
    logic          fe;
    logic          typed;
    level_report_t rep;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] sample_i = '0;
  logic               sample_valid_i = 1'b0;
  logic               frame_end_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [10:0] rms_level_tenths_db_o;
  logic signed [10:0] peak_level_tenths_db_o;
  logic [19:0]        clip_count_o;
  logic [4:0]         bar_fill_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [7:0]         cfg_data_i = '0;

  audio_rms_peak_level_meter_core u_top (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .sample_i               (sample_i),
    .sample_valid_i         (sample_valid_i),
    .frame_end_i            (frame_end_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .rms_level_tenths_db_o  (rms_level_tenths_db_o),
    .peak_level_tenths_db_o (peak_level_tenths_db_o),
    .clip_count_o           (clip_count_o),
    .bar_fill_o             (bar_fill_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_data_i             (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---- model state of the meter --------------------------------------------
  logic [63:0]   sq_acc;
  logic [15:0]   peak_acc;
  logic [63:0]   clip_acc;
  logic [63:0]   cnt_acc;
  logic [7:0]    frame_acc;
  logic [7:0]    fpr_shadow;

  level_report_t pending_reports[$];
  int            error_count = 0;
  int            cycle_count = 0;
  bit            calm = 1'b0;   // when set, neither side idles

  // log2 in Q24: integer part is the top bit, fraction by repeated squaring
  function automatic logic [63:0] log2_q24(logic [63:0] x);
    int          e;
    logic [63:0] m;
    logic [63:0] sq;
    logic [63:0] frac;
    e    = 63;
    frac = '0;
    while (!x[e]) e--;
    m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
    for (int i = 23; i >= 0; i--) begin
      sq = m * m;
      if (sq[63]) begin
        frac[i] = 1'b1;
        m = sq >> 32;
      end else begin
        m = sq >> 31;
      end
    end
    return (64'(e) << 24) | frac;
  endfunction

  // attenuation of num / (den * 2^30) in tenths of dB, 0..960
  function automatic int attenuation_tenths(logic [63:0] num, logic [63:0] den);
    logic [63:0] ln;
    logic [63:0] ld;
    logic [63:0] mag;
    logic [63:0] r;
    if (num == 0 || den == 0) return 960;
    ln = log2_q24(num);
    ld = log2_q24(den) + (64'd30 << 24);
    if (ln >= ld) return 0;
    mag = ld - ln;
    if (mag > (64'd1 << 31)) return 960;
    r = (mag * 64'(LOG_K) + (64'd1 << 47)) >> 48;
    return (r > 960) ? 960 : int'(r);
  endfunction

  // advance the model by one accepted item; returns 1 with a report
  function automatic bit meter_step(logic [15:0] smp, logic sv, logic fe,
                                    output level_report_t rep);
    logic [63:0] a;
    logic [63:0] sq;
    logic [7:0]  lim;
    int          rms;
    int          pk;
    int          fill;
    rep = '0;
    lim = (fpr_shadow == 0) ? 8'd1 : fpr_shadow;
    if (sv) begin
      a  = smp[15] ? (64'h10000 - 64'(smp)) : 64'(smp);
      sq = a * a;
      sq_acc = (SUM_CAP - sq_acc < sq) ? SUM_CAP : sq_acc + sq;
      if (a > 64'(peak_acc)) peak_acc = a[15:0];
      if (a >= 32767 && clip_acc < CNT_CAP) clip_acc++;
      if (cnt_acc < CNT_CAP) cnt_acc++;
    end
    if (!fe) return 1'b0;
    if (frame_acc < 8'd255) frame_acc++;
    if (frame_acc < lim) return 1'b0;
    rms  = -attenuation_tenths(sq_acc, cnt_acc);
    pk   = -attenuation_tenths(64'(peak_acc) * 64'(peak_acc), 64'd1);
    if (rms + 600 <= 0) fill = 0;
    else begin
      fill = ((rms + 600) * BAR_CELLS_DEF + 300) / 600;
      if (fill > BAR_CELLS_DEF) fill = BAR_CELLS_DEF;
    end
    rep.rms  = 11'(rms);
    rep.peak = 11'(pk);
    rep.clip = (clip_acc > 64'hFFFFF) ? 20'hFFFFF : clip_acc[19:0];
    rep.bar  = 5'(fill);
    sq_acc = '0; peak_acc = '0; clip_acc = '0; cnt_acc = '0; frame_acc = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // ---- drivers --------------------------------------------------------------
  // valid stays high between back-to-back items; lowered only when a gap is drawn
  task automatic send_item(logic [15:0] smp, logic sv, logic fe, bit typed,
                           level_report_t typed_rep);
    int            gap;
    level_report_t rep;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    sample_i       <= smp;
    sample_valid_i <= sv;
    frame_end_i    <= fe;
    do @(posedge clk_i); while (!in_ready_o);
    if (meter_step(smp, sv, fe, rep))
      pending_reports.push_back(typed ? typed_rep : rep);
  endtask

  // idle the input, let every report come out, then the tail of the block
  task automatic drain_meter();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_fpr(logic [7:0] val);
    drain_meter();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    fpr_shadow = val;
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  // receiver: draws a stall before each transfer
  initial begin : out_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        @(negedge clk_i) out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i) out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // ---- checker --------------------------------------------------------------
  always @(posedge clk_i) begin
    level_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected report, rms", rms_level_tenths_db_o, 0);
      end else begin
        want = pending_reports.pop_front();
        if (rms_level_tenths_db_o !== want.rms)
          report_mismatch("rms", rms_level_tenths_db_o, want.rms);
        if (peak_level_tenths_db_o !== want.peak)
          report_mismatch("peak", peak_level_tenths_db_o, want.peak);
        if (clip_count_o !== want.clip)
          report_mismatch("clip_count", clip_count_o, want.clip);
        if (bar_fill_o !== want.bar)
          report_mismatch("bar_fill", bar_fill_o, want.bar);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("audio_rms_peak_level_meter_core_test: done, errors");
      $finish;
    end
  end

  // ---- directed table -------------------------------------------------------
  localparam level_report_t FLOOR_REP = '{rms: -11'sd960, peak: -11'sd960,
                                          clip: 20'd0, bar: 5'd0};
  localparam level_report_t FULL_REP  = '{rms: 11'sd0, peak: 11'sd0,
                                          clip: 20'd1, bar: 5'd20};
  localparam level_report_t NO_REP    = '0;
  localparam int DIR_ROWS = 25;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // reset setting of 5: four empty frames, the fifth reports the floor
    '{ROW_ITEM, 8'd0, 16'h0000, 1'b0, 1'b1, 1'b0, NO_REP},
    '{ROW_ITEM, 8'd0, 16'h0000, 1'b0, 1'b1, 1'b0, NO_REP},
    '{ROW_ITEM, 8'd0, 16'h0000, 1'b0, 1'b1, 1'b0, NO_REP},
    '{ROW_ITEM, 8'd0, 16'h0000, 1'b0, 1'b1, 1'b0, NO_REP},
    '{ROW_ITEM, 8'd0, 16'h0000, 1'b0, 1'b1, 1'b1, FLOOR_REP},
    '{ROW_CFG,  8'd1, 16'h0000, 1'b0, 1'b0, 1'b0, NO_REP},
    // most negative sample: full scale, one clip, bar full
    '{ROW_ITEM, 8'd0, 16'h8000, 1'b1, 1'b1, 1'b1, FULL_REP},
    '{ROW_ITEM, 8'd0, 16'h7FFF, 1'b1, 1'b0, 1'b0, NO_REP},
    '{ROW_ITEM, 8'd0, 16'h0001, 1'b1, 1'b1, 1'b0, NO_REP},
    // zero level gives the floor
    '{ROW_ITEM, 8'd0, 16'h0000, 1'b1, 1'b1, 1'b1, FLOOR_REP},
    '{ROW_ITEM, 8'd0, 16'h0001, 1'b1, 1'b1, 1'b0, NO_REP},
    '{ROW_ITEM, 8'd0, 16'hFFFF, 1'b1, 1'b1, 1'b0, NO_REP},
    '{ROW_ITEM, 8'd0, 16'h7FFF, 1'b1, 1'b1, 1'b0, NO_REP},
    '{ROW_ITEM, 8'd0, 16'h8001, 1'b1, 1'b1, 1'b0, NO_REP},
    // sample ignored when not marked valid
    '{ROW_ITEM, 8'd0, 16'h3039, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_ITEM, 8'd0, 16'h7FFF, 1'b0, 1'b1, 1'b1, FLOOR_REP},
    // zero setting acts as one
    '{ROW_CFG,  8'd0, 16'h0000, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_ITEM, 8'd0, 16'h8000, 1'b1, 1'b1, 1'b1, FULL_REP},
    // setting lowered below the frame count: next frame end reports
    '{ROW_CFG,  8'd3, 16'h0000, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_ITEM, 8'd0, 16'h0064, 1'b1, 1'b1, 1'b0, NO_REP},
    '{ROW_ITEM, 8'd0, 16'hFF38, 1'b1, 1'b0, 1'b0, NO_REP},
    '{ROW_ITEM, 8'd0, 16'h00C8, 1'b1, 1'b1, 1'b0, NO_REP},
    '{ROW_CFG,  8'd1, 16'h0000, 1'b0, 1'b0, 1'b0, NO_REP},
    '{ROW_ITEM, 8'd0, 16'h012C, 1'b1, 1'b1, 1'b0, NO_REP},
    '{ROW_ITEM, 8'd0, 16'h4000, 1'b1, 1'b1, 1'b0, NO_REP}
  };

  // random sample: extremes, small magnitudes or full range
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h8001;
      3:       return 16'h0000;
      4, 5:    return 16'($signed($urandom_range(0, 65535)) >>> $urandom_range(0, 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin : stimulus
    int          sent;
    int          frames;
    int          flen;
    logic [7:0]  fpr;
    logic [7:0]  fpr_plan [8];
    fpr_plan = '{8'd2, 8'd255, 8'd4, 8'd1, 8'd7, 8'd3, 8'd0, 8'd2};
    sq_acc = '0; peak_acc = '0; clip_acc = '0; cnt_acc = '0; frame_acc = '0;
    fpr_shadow = FPR_RESET;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_fpr(dir_rows[i].cfg);
      else send_item(dir_rows[i].smp, dir_rows[i].sv, dir_rows[i].fe,
                     dir_rows[i].typed, dir_rows[i].rep);
    end

    // random phases; the plan runs first, then random settings
    sent = 0;
    for (int ph = 0; sent < RANDOM_ITEMS; ph++) begin
      fpr = (ph < 8) ? fpr_plan[ph] : 8'($urandom_range(1, 6));
      write_fpr(fpr);
      calm   = ($urandom_range(0, 3) == 0);
      frames = (fpr == 8'd255) ? 255 : ((fpr == 0) ? 1 : fpr) * $urandom_range(2, 5);
      for (int f = 0; f < frames; f++) begin
        flen = (fpr == 8'd255) ? $urandom_range(1, 2) : $urandom_range(1, 6);
        for (int k = 0; k < flen; k++) begin
          // mostly real samples, some empty markers
          send_item(pick_sample(), ($urandom_range(0, 9) != 0), (k == flen - 1),
                    1'b0, NO_REP);
          sent++;
        end
      end
    end

    calm = 1'b0;
    drain_meter();
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("audio_rms_peak_level_meter_core_test: done, clean");
    end else begin
      $display("audio_rms_peak_level_meter_core_test: done, errors");
    end
    $finish;
  end

endmodule
